// File: rtl/core/pitt_pkg.sv
// Package for the point-in-tetrahedron test unit.
// Holds widths, reset constants and the controller state type; no dependencies.
`timescale 1ns / 1ps
package pitt_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int DET_BITS = 52;
  localparam int SHIFT_BITS = 6;
  localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = 6'd20;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOX,
    ST_DET,
    ST_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic box_start;
    logic det_start;
    logic det_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_box;
    logic det_last;
  } status_t;
endpackage

// File: rtl/core/point_in_tetrahedron_test_unit.sv
// Top level of the point-in-tetrahedron test unit.
// Instantiates pitt_ctrl and pitt_datapath; depends on pitt_pkg.
`timescale 1ns / 1ps
// A vertex load produces no result. A test ends early when the point falls
// outside the bounding box; otherwise five
// determinants of six terms each run through one shared two-stage multiplier,
// seven steps per determinant. One request is worked on at a time; the result
// holds in its output register until taken.
module point_in_tetrahedron_test_unit #(
  parameter int COORD_BITS = pitt_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic op,
  input  logic [1:0] vertex_index,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] coord_z,
  output logic out_valid,
  input  logic out_ready,
  output logic inside_res,
  output logic in_box,
  output logic signed [pitt_pkg::DET_BITS-1:0] det_whole,
  output logic signed [pitt_pkg::DET_BITS-1:0] det_first,
  output logic signed [pitt_pkg::DET_BITS-1:0] det_second,
  output logic signed [pitt_pkg::DET_BITS-1:0] det_third,
  output logic signed [pitt_pkg::DET_BITS-1:0] det_fourth,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [pitt_pkg::SHIFT_BITS-1:0] cfg_data
);
  import pitt_pkg::*;
  cmd_t cmd;
  status_t status;
  logic [SHIFT_BITS-1:0] tolerance_shift;
  logic signed [DET_BITS-1:0] det_res [5];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) tolerance_shift <= SHIFT_RESET;
    else if (cfg_valid) tolerance_shift <= cfg_data;
  end

  pitt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .op, .out_valid, .out_ready,
    .cmd, .status
  );

  pitt_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk, .rst, .cmd, .status, .vertex_index, .coord_x, .coord_y, .coord_z,
    .tolerance_shift, .inside_res, .in_box, .det_res
  );

  assign det_whole = det_res[0];
  assign det_first = det_res[1];
  assign det_second = det_res[2];
  assign det_third = det_res[3];
  assign det_fourth = det_res[4];

`ifndef SYNTHESIS
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_box) |-> (!inside_res && det_whole == '0))
    else $error("rejected point has nonzero result");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(det_whole)))
    else $error("result dropped before taken");
`endif
endmodule

// File: rtl/core/pitt_datapath.sv
// Datapath: vertex store, bounding box, and a shared multiplier sequenced over
// five determinants. Depends on pitt_pkg.
`timescale 1ns / 1ps
module pitt_datapath #(
  parameter int COORD_BITS = pitt_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  pitt_pkg::cmd_t cmd,
  output pitt_pkg::status_t status,
  input  logic [1:0] vertex_index,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] coord_z,
  input  logic [pitt_pkg::SHIFT_BITS-1:0] tolerance_shift,
  output logic inside_res,
  output logic in_box,
  output logic signed [pitt_pkg::DET_BITS-1:0] det_res [5]
);
  import pitt_pkg::*;
  localparam int CB = COORD_BITS;
  localparam int EB = CB + 1;
  localparam int PB = 2 * EB;

  logic signed [CB-1:0] vs [4][3];
  logic signed [CB-1:0] lo [3];
  logic signed [CB-1:0] hi [3];
  logic signed [CB-1:0] pt [3];
  logic signed [CB-1:0] nv [3];
  logic signed [DET_BITS-1:0] acc [5];
  logic [2:0] di;   // determinant index
  logic [2:0] ti;   // term index 0..5 plus a drain step
  logic signed [PB-1:0] prod;
  logic signed [EB-1:0] mul_c;
  logic [2:0] ti_d;
  logic       prod_v;
  logic signed [CB-1:0] px [4][3];
  logic signed [EB-1:0] e [3][3];
  logic signed [EB-1:0] ma, mb;
  logic signed [DET_BITS-1:0] d0, z0, nz0, term;
  logic inb;
  logic pos, ok_pos, ok_neg;
  logic load_d;
  logic signed [CB-1:0] mn [3];
  logic signed [CB-1:0] mx [3];

  assign nv[0] = coord_x[CB-1:0];
  assign nv[1] = coord_y[CB-1:0];
  assign nv[2] = coord_z[CB-1:0];

  always_comb begin
    inb = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (pt[a] < lo[a] || pt[a] > hi[a]) inb = 1'b0;
    end
  end

  // Vertex set for the current determinant: the point replaces vertex di-1.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int a = 0; a < 3; a++) begin
        px[k][a] = (di == 3'(k + 1)) ? pt[a] : vs[k][a];
      end
    end
    for (int r = 0; r < 3; r++) begin
      for (int a = 0; a < 3; a++) begin
        e[r][a] = EB'(px[r+1][a]) - EB'(px[0][a]);
      end
    end
    // Terms: ax*by*cz, ay*bz*cx, az*bx*cy, -az*by*cx, -ay*bx*cz, -ax*bz*cy.
    unique case (ti)
      3'd0: begin ma = e[0][0]; mb = e[1][1]; end
      3'd1: begin ma = e[0][1]; mb = e[1][2]; end
      3'd2: begin ma = e[0][2]; mb = e[1][0]; end
      3'd3: begin ma = e[0][2]; mb = e[1][1]; end
      3'd4: begin ma = e[0][1]; mb = e[1][0]; end
      default: begin ma = e[0][0]; mb = e[1][2]; end
    endcase
  end

  // Second factor for the registered product, chosen by the delayed index.
  always_comb begin
    unique case (ti_d)
      3'd0, 3'd4: mul_c = e[2][2];
      3'd1, 3'd3: mul_c = e[2][0];
      default:    mul_c = e[2][1];
    endcase
    term = DET_BITS'(prod) * DET_BITS'(mul_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++)
        for (int a = 0; a < 3; a++) vs[k][a] <= '0;
      di <= '0;
      ti <= '0;
      prod_v <= 1'b0;
    end else begin
      prod_v <= 1'b0;
      if (cmd.load) begin
        for (int a = 0; a < 3; a++) vs[vertex_index][a] <= nv[a];
      end
      if (cmd.box_start) begin
        for (int a = 0; a < 3; a++) pt[a] <= nv[a];
      end
      if (cmd.det_start) begin
        di <= '0;
        ti <= '0;
        for (int k = 0; k < 5; k++) acc[k] <= '0;
      end else if (cmd.det_step) begin
        if (ti != 3'd6) prod_v <= 1'b1;
        prod <= PB'(ma) * PB'(mb);
        ti_d <= ti;
        if (ti == 3'd6) begin
          ti <= '0;
          di <= di + 3'd1;
        end else begin
          ti <= ti + 3'd1;
        end
      end
      // Negated determinant: first three terms subtract, last three add.
      if (prod_v) begin
        if (ti_d < 3'd3) acc[di] <= acc[di] - term;
        else acc[di] <= acc[di] + term;
      end
      if (cmd.finish) begin
        inside_res <= inb & (pos ? ok_pos : ok_neg);
        in_box <= inb;
        for (int k = 0; k < 5; k++) det_res[k] <= inb ? acc[k] : '0;
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mn[a] = vs[0][a];
      mx[a] = vs[0][a];
      for (int k = 1; k < 4; k++) begin
        if (vs[k][a] < mn[a]) mn[a] = vs[k][a];
        if (vs[k][a] > mx[a]) mx[a] = vs[k][a];
      end
    end
  end

  // The box follows the store in the cycle after each load.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_d <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        lo[a] <= '0;
        hi[a] <= '0;
      end
    end else begin
      load_d <= cmd.load;
      if (load_d) begin
        for (int a = 0; a < 3; a++) begin
          lo[a] <= mn[a];
          hi[a] <= mx[a];
        end
      end
    end
  end

  always_comb begin
    d0 = acc[0];
    z0 = d0 >>> tolerance_shift;
    nz0 = -z0;
    pos = d0 > z0;
    ok_pos = 1'b1;
    ok_neg = 1'b1;
    for (int k = 1; k < 5; k++) begin
      if (acc[k] < z0) ok_pos = 1'b0;
      if (acc[k] > nz0) ok_neg = 1'b0;
    end
  end

  assign status.in_box = inb & ~load_d;
  assign status.det_last = (di == 3'd4) && (ti == 3'd6);
endmodule

// File: rtl/core/pitt_ctrl.sv
// Controller state machine for the point-in-tetrahedron test unit.
// Depends on pitt_pkg.
`timescale 1ns / 1ps
module pitt_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic op,
  output logic out_valid,
  input  logic out_ready,
  output pitt_pkg::cmd_t cmd,
  input  pitt_pkg::status_t status
);
  import pitt_pkg::*;
  state_t state, state_next;
  logic acc_in;
  assign acc_in = in_valid & in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (acc_in && op == OP_TEST) state_next = ST_BOX;
      ST_BOX:  state_next = status.in_box ? ST_DET : ST_DONE;
      ST_DET:  if (status.det_last) state_next = ST_DONE;
      ST_DONE: state_next = ST_OUT;
      ST_OUT:  if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    cmd.load = acc_in && op == OP_LOAD;
    cmd.box_start = acc_in && op == OP_TEST;
    cmd.det_start = (state == ST_BOX);
    cmd.det_step = (state == ST_DET);
    cmd.finish = (state == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end
endmodule
